// ===== rtl/rsalu_pkg.sv =====
package rsalu_pkg;

	// Default sizes of the stack and of one entry.
	localparam int DEPTH_DEFAULT      = 32;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// A dump never emits more entries than this.
	localparam int DUMP_MAX = 32;

	// Port widths fixed by the command format.
	localparam int OPCODE_W  = 3;
	localparam int OPERAND_W = 32;
	localparam int RESULT_W  = 32;
	localparam int STATUS_W  = 2;

	// Command codes.
	localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_DUMP = 3'd5;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO  = 2'd3;

endpackage

// ===== rtl/rpn_stack_alu_top.sv =====
// Stack calculator: push writes the stack straight from idle; add and subtract read the two
// top entries, then take one pass through the shared adder that the sequencer steps one bit
// per cycle for multiply and divide. A dump streams one entry per cycle. A new command is
// taken once busy is low. The receiver cannot stall: each result is shown for exactly one
// cycle under strobe. The asynchronous active-low reset empties the stack and idles the
// sequencer; no clearing pass.
module rpn_stack_alu_top #(
	parameter int DEPTH      = rsalu_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = rsalu_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [rsalu_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [rsalu_pkg::OPERAND_W-1:0] operand,
	output logic                                  strobe,
	output logic signed [rsalu_pkg::RESULT_W-1:0] result_value,
	output logic [rsalu_pkg::STATUS_W-1:0]        status,
	output logic                                  last
);

	localparam int AddrW = $clog2(DEPTH);
	localparam int FillW = $clog2(DEPTH + 1);
	localparam int CntW  = $clog2(DATA_WIDTH);
	// The shared adder carries two extra bits so that the divider's trial subtract
	// on a DATA_WIDTH+1 bit partial remainder shows its sign in the top bit.
	localparam int AddW  = DATA_WIDTH + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_A,
		S_LOAD,
		S_EXEC,
		S_MUL,
		S_ABS_A,
		S_ABS_B,
		S_DIV,
		S_FIX,
		S_DUMP
	} state_t;

	state_t state_q;

	// The stack itself: one write port and one registered read port.
	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  rd_en;
	logic [AddrW-1:0]      rd_addr;
	logic                  wr_en;
	logic [AddrW-1:0]      wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	// Fill level and the working registers of the shared unit. During a multiply,
	// a_q is the shifted multiplicand, b_q the shifted multiplier and acc_q the
	// product. During a divide, a_q holds the dividend bits shifting out at the top
	// and the quotient bits shifting in at the bottom, acc_q the partial remainder.
	logic [FillW-1:0]          fill_q;
	logic [FillW-1:0]          idx_q;
	logic [rsalu_pkg::OPCODE_W-1:0] op_q;
	logic [DATA_WIDTH-1:0]     a_q;
	logic [DATA_WIDTH-1:0]     b_q;
	logic [DATA_WIDTH-1:0]     acc_q;
	logic [CntW-1:0]           cnt_q;
	logic                      neg_q;

	logic                      strobe_q;
	logic [rsalu_pkg::RESULT_W-1:0]  result_q;
	logic [rsalu_pkg::STATUS_W-1:0]  status_q;
	logic                      last_q;

	logic                  accept;
	logic                  full;
	logic                  few;
	logic [FillW-1:0]      fill_m1;
	logic [FillW-1:0]      fill_m2;
	logic [FillW-1:0]      idx_p1;
	logic                  dump_last;
	logic [DATA_WIDTH-1:0] push_data;
	logic signed [63:0]    operand_wide;

	logic [AddW-1:0]       add_x;
	logic [AddW-1:0]       add_y;
	logic                  add_sub;
	logic [AddW-1:0]       add_sum;
	logic                  div_ge;

	logic                  commit;
	logic [DATA_WIDTH-1:0] commit_val;
	logic [DATA_WIDTH-1:0] out_src;
	logic signed [63:0]    out_wide;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign full    = (fill_q == FillW'(DEPTH));
	assign few     = (fill_q < FillW'(2));
	assign fill_m1 = fill_q - FillW'(1);
	assign fill_m2 = fill_q - FillW'(2);
	assign idx_p1  = idx_q + FillW'(1);

	// A dump ends at the top of the stack or at the output limit, whichever comes first.
	assign dump_last = ((FillW + 1)'(idx_q) + (FillW + 1)'(1) == (FillW + 1)'(fill_q)) ||
		(32'(idx_q) + 32'd1 == 32'(rsalu_pkg::DUMP_MAX));

	// The operand is sign-extended, then cut to the entry width.
	assign operand_wide = 64'(operand);
	assign push_data    = operand_wide[DATA_WIDTH-1:0];

	// The shared adder. Every arithmetic step of every command goes through it:
	// add, subtract, one multiply step, one divide step, and the negations that
	// turn signed division into a divide of magnitudes.
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				add_x   = AddW'(a_q);
				add_y   = AddW'(b_q);
				add_sub = (op_q == rsalu_pkg::OP_SUB);
			end
			S_MUL: begin
				add_x = AddW'(acc_q);
				add_y = AddW'(a_q);
			end
			S_ABS_A, S_FIX: begin
				add_y   = AddW'(a_q);
				add_sub = 1'b1;
			end
			S_ABS_B: begin
				add_y   = AddW'(b_q);
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_x   = {1'b0, acc_q, a_q[DATA_WIDTH-1]};
				add_y   = AddW'(b_q);
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = add_x + (add_sub ? ~add_y : add_y) + AddW'(add_sub);
	// The trial subtract fits when it leaves no borrow.
	assign div_ge  = !add_sum[AddW-1];

	// An arithmetic command finishes here: the new top replaces the second entry.
	always_comb begin
		commit     = 1'b0;
		commit_val = add_sum[DATA_WIDTH-1:0];
		unique case (state_q)
			S_EXEC: begin
				commit = 1'b1;
			end
			S_MUL: begin
				commit     = (cnt_q == '0);
				commit_val = b_q[0] ? add_sum[DATA_WIDTH-1:0] : acc_q;
			end
			S_FIX: begin
				commit     = 1'b1;
				commit_val = neg_q ? add_sum[DATA_WIDTH-1:0] : a_q;
			end
			default: begin
			end
		endcase
	end

	// Results leave sign-extended from the entry width to the result width.
	assign out_src  = (state_q == S_DUMP) ? rd_data_q : commit_val;
	assign out_wide = 64'($signed(out_src));

	// Stack port addressing.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_m2[AddrW-1:0];
		wr_data = commit_val;
		if (state_q == S_IDLE) begin
			wr_en   = accept && (opcode == rsalu_pkg::OP_PUSH) && !full;
			wr_addr = fill_q[AddrW-1:0];
			wr_data = push_data;
		end else if (commit) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (opcode == rsalu_pkg::OP_DUMP) && (fill_q != '0)) begin
					rd_en = 1'b1;
				end else if (accept && !few && (opcode == rsalu_pkg::OP_ADD ||
						opcode == rsalu_pkg::OP_SUB || opcode == rsalu_pkg::OP_MUL ||
						opcode == rsalu_pkg::OP_DIV)) begin
					rd_en   = 1'b1;
					rd_addr = fill_m1[AddrW-1:0];
				end
			end
			S_RD_A: begin
				rd_en   = 1'b1;
				rd_addr = fill_m2[AddrW-1:0];
			end
			S_DUMP: begin
				rd_en   = !dump_last;
				rd_addr = idx_p1[AddrW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Sequencer with the stack level and the registered result ports.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= opcode;
						unique case (opcode) inside
							rsalu_pkg::OP_PUSH: begin
								if (full) begin
									strobe_q <= 1'b1;
									result_q <= '0;
									status_q <= rsalu_pkg::STATUS_FULL;
									last_q   <= 1'b1;
								end else begin
									fill_q <= fill_q + FillW'(1);
								end
							end
							rsalu_pkg::OP_ADD, rsalu_pkg::OP_SUB,
							rsalu_pkg::OP_MUL, rsalu_pkg::OP_DIV: begin
								if (few) begin
									strobe_q <= 1'b1;
									result_q <= '0;
									status_q <= rsalu_pkg::STATUS_UNDERFLOW;
									last_q   <= 1'b1;
								end else begin
									state_q <= S_RD_A;
								end
							end
							rsalu_pkg::OP_DUMP: begin
								if (fill_q != '0) begin
									idx_q   <= '0;
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_A: begin
					b_q     <= rd_data_q;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					a_q <= rd_data_q;
					unique case (op_q) inside
						rsalu_pkg::OP_ADD, rsalu_pkg::OP_SUB: begin
							state_q <= S_EXEC;
						end
						rsalu_pkg::OP_MUL: begin
							acc_q   <= '0;
							cnt_q   <= CntW'(DATA_WIDTH - 1);
							state_q <= S_MUL;
						end
						rsalu_pkg::OP_DIV: begin
							if (b_q == '0) begin
								strobe_q <= 1'b1;
								result_q <= '0;
								status_q <= rsalu_pkg::STATUS_DIV_ZERO;
								last_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								neg_q   <= rd_data_q[DATA_WIDTH-1] ^ b_q[DATA_WIDTH-1];
								state_q <= S_ABS_A;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MUL: begin
					if (b_q[0]) begin
						acc_q <= add_sum[DATA_WIDTH-1:0];
					end
					a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
					b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
					cnt_q <= cnt_q - CntW'(1);
				end
				S_ABS_A: begin
					if (a_q[DATA_WIDTH-1]) begin
						a_q <= add_sum[DATA_WIDTH-1:0];
					end
					state_q <= S_ABS_B;
				end
				S_ABS_B: begin
					if (b_q[DATA_WIDTH-1]) begin
						b_q <= add_sum[DATA_WIDTH-1:0];
					end
					acc_q   <= '0;
					cnt_q   <= CntW'(DATA_WIDTH - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					acc_q <= div_ge ? add_sum[DATA_WIDTH-1:0] :
						{acc_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
					a_q   <= {a_q[DATA_WIDTH-2:0], div_ge};
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_DUMP: begin
					strobe_q <= 1'b1;
					result_q <= out_wide[rsalu_pkg::RESULT_W-1:0];
					status_q <= rsalu_pkg::STATUS_OK;
					last_q   <= dump_last;
					idx_q    <= idx_p1;
					if (dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
				end
			endcase
			// Any arithmetic command that completes pops one entry and reports the new top.
			if (commit) begin
				fill_q   <= fill_m1;
				strobe_q <= 1'b1;
				result_q <= out_wide[rsalu_pkg::RESULT_W-1:0];
				status_q <= rsalu_pkg::STATUS_OK;
				last_q   <= 1'b1;
				state_q  <= S_IDLE;
			end
		end
	end

	assign strobe       = strobe_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign last         = last_q;

	// The stack level never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FillW'(DEPTH))
		else $error("stack level above capacity");

	// A push on a stack with room grows it by one and gives no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (opcode == rsalu_pkg::OP_PUSH) && !full
		|=> (fill_q == $past(fill_q) + FillW'(1)) && !strobe)
		else $error("push did not grow the stack");

	// Every error result is a lone, final result with a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != rsalu_pkg::STATUS_OK) |-> last && (result_value == '0))
		else $error("malformed error result");

	// The final result of a command frees the block for the next transfer.
	assert property (@(posedge clk) disable iff (!arst_n) strobe && last |-> !busy)
		else $error("busy after final result");

endmodule
